### sv/dd_pkg.sv
// ----------------------------------------------------------------------------
// Deadlock detector package
// Shared constants and function codes for the deadlock detector.
// ----------------------------------------------------------------------------
package dd_pkg;

    localparam int DEF_MAX_PROCS  = 16;
    localparam int DEF_MAX_TYPES  = 8;
    localparam int DEF_COUNT_BITS = 16;

    localparam int FUNC_W  = 3;
    localparam int PROC_W  = 4;
    localparam int TYPE_W  = 3;
    localparam int VALUE_W = 16;
    localparam int NCNT_W  = 5;
    localparam int CFG_W   = 5;

    localparam logic [FUNC_W-1:0] FN_LOAD_ALLOC = 3'd0;
    localparam logic [FUNC_W-1:0] FN_LOAD_REQ   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_LOAD_AVAIL = 3'd2;
    localparam logic [FUNC_W-1:0] FN_ABORT      = 3'd3;
    localparam logic [FUNC_W-1:0] FN_DETECT     = 3'd4;

    localparam logic CFG_NUM_PROCS = 1'b0;
    localparam logic CFG_NUM_TYPES = 1'b1;

endpackage

### sv/deadlock_detector.sv
// ----------------------------------------------------------------------------
// Deadlock detector
// Multi-instance deadlock detection over allocation and request matrices.
// ----------------------------------------------------------------------------
// A load of an allocation or request entry passes through the write state; a
// load of an available entry is written straight from idle. An abort reads and
// then updates each resource type in use. A detect first copies the available
// vector type by type, then walks the processes through a single shared compare
// and saturating adder. A row compares request against work one type at a time,
// adds its allocation back type by type when it finishes, and then steps to the
// next row. Passes repeat until one finishes nothing. The deadlocked ids then
// follow one per cycle. Each result is shown for one cycle on o_valid and cannot
// be stalled; busy stays high until the last result has gone out.
module deadlock_detector #(
    parameter int MAX_PROCS  = dd_pkg::DEF_MAX_PROCS,
    parameter int MAX_TYPES  = dd_pkg::DEF_MAX_TYPES,
    parameter int COUNT_BITS = dd_pkg::DEF_COUNT_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [dd_pkg::FUNC_W-1:0]  i_func,
    input  logic [dd_pkg::PROC_W-1:0]  i_proc_index,
    input  logic [dd_pkg::TYPE_W-1:0]  i_type_index,
    input  logic [dd_pkg::VALUE_W-1:0] i_value,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic                       i_cfg_index,
    input  logic [dd_pkg::CFG_W-1:0]   i_cfg_data,
    output logic                       o_valid,
    output logic [dd_pkg::PROC_W-1:0]  o_proc_id,
    output logic                       o_has_proc,
    output logic [dd_pkg::NCNT_W-1:0]  o_deadlocked_count,
    output logic                       o_last
);
    import dd_pkg::*;

    localparam int PW    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int TW    = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;
    localparam int DEPTH = MAX_PROCS * MAX_TYPES;
    localparam int AW    = PW + TW;
    localparam int NPW   = $clog2(MAX_PROCS + 1);
    localparam int NTW   = $clog2(MAX_TYPES + 1);
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

    typedef enum logic [3:0] {
        S_IDLE, S_WRITE, S_AB_RD, S_AB_UPD, S_CP, S_ROW, S_CMP, S_ADD_RD,
        S_ADD, S_NEXT, S_EMIT
    } t_state;

    t_state                r_state;
    logic [CFG_W-1:0]      r_num_procs;
    logic [CFG_W-1:0]      r_num_types;

    logic [COUNT_BITS-1:0] r_alloc [DEPTH];
    logic [COUNT_BITS-1:0] r_req   [DEPTH];
    logic [DEPTH-1:0]      r_alloc_vld;
    logic [DEPTH-1:0]      r_req_vld;
    logic [COUNT_BITS-1:0] r_avail [MAX_TYPES];
    logic [COUNT_BITS-1:0] r_work  [MAX_TYPES];
    logic [MAX_PROCS-1:0]  r_fin;

    logic [FUNC_W-1:0]     r_func;
    logic [PW-1:0]         r_p;
    logic [TW-1:0]         r_t;
    logic [COUNT_BITS-1:0] r_v;
    logic                  r_prog;
    logic [COUNT_BITS-1:0] r_ad;
    logic [COUNT_BITS-1:0] r_rd;
    logic [NPW-1:0]        r_cnt;
    logic [NPW-1:0]        r_emitted;

    logic                  r_ovalid;
    logic [PROC_W-1:0]     r_oid;
    logic                  r_ohas;
    logic [NCNT_W-1:0]     r_ocnt;
    logic                  r_olast;

    logic [NPW-1:0]        np;
    logic [NTW-1:0]        nt;
    logic [AW-1:0]         addr;
    logic [COUNT_BITS-1:0] a_val;
    logic [COUNT_BITS-1:0] r_val;
    logic [COUNT_BITS:0]   sum_wide;
    logic [COUNT_BITS-1:0] sum_sat;
    logic [COUNT_BITS-1:0] add_a;
    logic                  t_end;
    logic                  p_end;
    logic [MAX_PROCS-1:0]  open_mask;
    logic [NPW-1:0]        open_cnt;
    logic [PW-1:0]         next_open;
    logic                  any_open;
    logic [COUNT_BITS-1:0] v_sat;

    always_comb begin
        if (r_num_procs == '0) begin
            np = NPW'(1);
        end else if (32'(r_num_procs) > MAX_PROCS) begin
            np = NPW'(MAX_PROCS);
        end else begin
            np = NPW'(r_num_procs);
        end
        if (r_num_types == '0) begin
            nt = NTW'(1);
        end else if (32'(r_num_types) > MAX_TYPES) begin
            nt = NTW'(MAX_TYPES);
        end else begin
            nt = NTW'(r_num_types);
        end
    end

    assign addr  = {r_p, r_t};
    assign a_val = r_alloc_vld[addr] ? r_ad : '0;
    assign r_val = r_req_vld[addr] ? r_rd : '0;
    assign add_a = (r_state == S_AB_UPD) ? r_avail[r_t] : r_work[r_t];
    assign sum_wide = {1'b0, add_a} + {1'b0, a_val};
    assign sum_sat  = sum_wide[COUNT_BITS] ? CMAX : sum_wide[COUNT_BITS-1:0];
    assign t_end = (NTW'(r_t) + NTW'(1)) >= nt;
    assign p_end = (NPW'(r_p) + NPW'(1)) >= np;

    always_comb begin
        if (32'(i_value) > 32'(CMAX)) begin
            v_sat = CMAX;
        end else begin
            v_sat = COUNT_BITS'(i_value);
        end
    end

    always_comb begin
        open_cnt  = '0;
        next_open = '0;
        any_open  = 1'b0;
        for (int i = MAX_PROCS - 1; i >= 0; i--) begin
            open_mask[i] = !r_fin[i] && (i < 32'(np));
            if (open_mask[i]) begin
                open_cnt = open_cnt + NPW'(1);
            end
            if (open_mask[i] && (i > 32'(r_p) || (r_emitted == '0 && i >= 32'(r_p)))) begin
                next_open = PW'(i);
                any_open  = 1'b1;
            end
        end
    end

    // Memory read port: one registered read of each matrix per cycle.
    always_ff @(posedge i_clk) begin
        r_ad <= r_alloc[addr];
        r_rd <= r_req[addr];
        if (r_state == S_WRITE && r_func == FN_LOAD_ALLOC) begin
            r_alloc[addr] <= r_v;
        end
        if (r_state == S_WRITE && r_func == FN_LOAD_REQ) begin
            r_req[addr] <= r_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_num_procs <= CFG_W'(1);
            r_num_types <= CFG_W'(1);
            r_alloc_vld <= '0;
            r_req_vld   <= '0;
            r_fin       <= '0;
            r_ovalid    <= 1'b0;
            for (int j = 0; j < MAX_TYPES; j++) begin
                r_avail[j] <= '0;
            end
        end else begin
            r_ovalid <= 1'b0;
            if (i_cfg_valid && r_state == S_IDLE) begin
                case (i_cfg_index)
                    CFG_NUM_PROCS: r_num_procs <= i_cfg_data;
                    CFG_NUM_TYPES: r_num_types <= {1'b0, i_cfg_data[3:0]};
                    default:       r_num_procs <= r_num_procs;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (start && !r_ovalid) begin
                        r_func <= i_func;
                        r_p    <= PW'(i_proc_index);
                        r_t    <= TW'(i_type_index);
                        r_v    <= v_sat;
                        case (i_func)
                            FN_LOAD_ALLOC, FN_LOAD_REQ: begin
                                if (32'(i_proc_index) < 32'(np)
                                    && 32'(i_type_index) < 32'(nt)) begin
                                    r_state <= S_WRITE;
                                end
                            end
                            FN_LOAD_AVAIL: begin
                                if (32'(i_type_index) < 32'(nt)) begin
                                    r_avail[TW'(i_type_index)] <= v_sat;
                                end
                            end
                            FN_ABORT: begin
                                if (32'(i_proc_index) < 32'(np)) begin
                                    r_t     <= '0;
                                    r_state <= S_AB_RD;
                                end
                            end
                            FN_DETECT: begin
                                r_t     <= '0;
                                r_fin   <= '0;
                                r_state <= S_CP;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_WRITE: begin
                    if (r_func == FN_LOAD_ALLOC) begin
                        r_alloc_vld[addr] <= 1'b1;
                    end else begin
                        r_req_vld[addr] <= 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                S_AB_RD: r_state <= S_AB_UPD;
                S_AB_UPD: begin
                    r_avail[r_t]      <= sum_sat;
                    r_alloc_vld[addr] <= 1'b0;
                    r_req_vld[addr]   <= 1'b0;
                    r_t               <= r_t + TW'(1);
                    r_state           <= t_end ? S_IDLE : S_AB_RD;
                end
                S_CP: begin
                    r_work[r_t] <= r_avail[r_t];
                    r_t         <= r_t + TW'(1);
                    if (t_end) begin
                        r_t     <= '0;
                        r_p     <= '0;
                        r_prog  <= 1'b0;
                        r_state <= S_ROW;
                    end
                end
                S_ROW: begin
                    r_state <= r_fin[r_p] ? S_NEXT : S_CMP;
                end
                S_CMP: begin
                    if (r_val > r_work[r_t]) begin
                        r_state <= S_NEXT;
                    end else if (t_end) begin
                        r_t     <= '0;
                        r_state <= S_ADD_RD;
                    end else begin
                        r_t     <= r_t + TW'(1);
                        r_state <= S_ROW;
                    end
                end
                S_ADD_RD: r_state <= S_ADD;
                S_ADD: begin
                    r_work[r_t] <= sum_sat;
                    r_t         <= r_t + TW'(1);
                    if (t_end) begin
                        r_fin[r_p] <= 1'b1;
                        r_prog     <= 1'b1;
                        r_state    <= S_NEXT;
                    end else begin
                        r_state <= S_ADD_RD;
                    end
                end
                S_NEXT: begin
                    r_t <= '0;
                    if (!p_end) begin
                        r_p     <= r_p + PW'(1);
                        r_state <= S_ROW;
                    end else if (r_prog) begin
                        r_p     <= '0;
                        r_prog  <= 1'b0;
                        r_state <= S_ROW;
                    end else begin
                        r_p       <= '0;
                        r_emitted <= '0;
                        r_cnt     <= open_cnt;
                        r_state   <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    r_ovalid <= 1'b1;
                    r_ocnt   <= NCNT_W'(r_cnt);
                    if (r_cnt == '0) begin
                        r_oid   <= '0;
                        r_ohas  <= 1'b0;
                        r_olast <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_oid     <= PROC_W'(next_open);
                        r_ohas    <= 1'b1;
                        r_p       <= next_open;
                        r_emitted <= r_emitted + NPW'(1);
                        r_olast   <= (r_emitted + NPW'(1)) == r_cnt;
                        if ((r_emitted + NPW'(1)) == r_cnt) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy               = (r_state != S_IDLE) || r_ovalid;
    assign o_cfg_ready        = (r_state == S_IDLE);
    assign o_valid            = r_ovalid;
    assign o_proc_id          = r_oid;
    assign o_has_proc         = r_ohas;
    assign o_deadlocked_count = r_ocnt;
    assign o_last             = r_olast;

    a_not_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> busy) else $error("busy low while working");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> r_state == S_IDLE) else $error("run not ended");
    a_has_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_has_proc) |-> (o_deadlocked_count == '0 && o_last))
        else $error("empty result malformed");
    a_emit_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_EMIT) |-> $past(r_state) == S_NEXT)
        else $error("emit without scan");

endmodule
